>>> rtl/core/fsei_pkg.sv
// Package: shared types and constants for the filtered sorted entry index.
package fsei_pkg;
  localparam int Capacity  = 1024;
  localparam int KindCount = 1025;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = IdxW + 1;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_SELECT = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [2:0] MODE_ONE     = 3'd0;
  localparam logic [2:0] MODE_GROUP   = 3'd1;
  localparam logic [2:0] MODE_RECENT  = 3'd2;
  localparam logic [2:0] MODE_BYKIND  = 3'd3;
  localparam logic [2:0] MODE_BYSLOT  = 3'd4;
  localparam logic [2:0] MODE_FLAGGED = 3'd5;

  typedef struct packed {
    logic [31:0] id;
    logic [9:0]  slot;
    logic [10:0] kind;
    logic        flag;
  } rec_t;

  // One classified request, handed from front to back.
  typedef struct packed {
    logic [1:0]  req;
    logic        ok;
    rec_t        rec;
    logic [2:0]  mode;
    logic [10:0] first;
    logic [10:0] last;
    logic [15:0] row;
  } cmd_t;

  function automatic logic [10:0] group_bound(input logic [3:0] g);
    logic [10:0] b;
    begin
      case (g)
        4'd1: b = 11'd151;
        4'd2: b = 11'd251;
        4'd3: b = 11'd386;
        4'd4: b = 11'd493;
        4'd5: b = 11'd649;
        4'd6: b = 11'd721;
        4'd7: b = 11'd809;
        4'd8: b = 11'd905;
        4'd9: b = 11'd1025;
        default: b = 11'd0;
      endcase
      return b;
    end
  endfunction

  // True if a must come strictly before b.
  function automatic logic goes_before(input rec_t a, input rec_t b, input logic [2:0] mode);
    logic r;
    begin
      if (mode == MODE_BYSLOT) r = a.slot < b.slot;
      else if (mode == MODE_GROUP || mode == MODE_BYKIND)
        r = (a.kind != b.kind) ? (a.kind < b.kind) : (a.id < b.id);
      else r = a.id > b.id;
      return r;
    end
  endfunction
endpackage

>>> rtl/core/fsei_front.sv
// Front: accepts requests, checks and classifies them into commands.
module fsei_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         q_full,
  input  logic [1:0]   req_type,
  input  logic [31:0]  rec_id,
  input  logic [15:0]  rec_slot,
  input  logic [15:0]  rec_kind,
  input  logic         rec_flag,
  input  logic [2:0]   view_mode,
  input  logic [15:0]  view_arg,
  input  logic [15:0]  row_index,
  output logic         busy,
  output logic         q_push,
  output fsei_pkg::cmd_t q_cmd
);
  import fsei_pkg::*;

  logic [CntW-1:0] tot;
  logic add_ok, sel_ok, acc;
  cmd_t c;

  assign busy = q_full || rst;
  assign acc  = start && !busy;

  always_comb begin
    add_ok = (tot < CntW'(Capacity)) && (rec_slot < 16'(Capacity)) && (rec_id != 32'd0)
             && (rec_kind != 16'd0) && (rec_kind <= 16'(KindCount));
    c = '0;
    c.req = req_type;
    c.rec.id = rec_id;
    c.rec.slot = rec_slot[9:0];
    c.rec.kind = rec_kind[10:0];
    c.rec.flag = rec_flag;
    c.mode = view_mode;
    c.row = row_index;
    c.first = 11'd1;
    c.last = 11'(KindCount);
    sel_ok = 1'b1;
    if (view_mode == MODE_ONE) begin
      sel_ok = (view_arg != 16'd0) && (view_arg <= 16'(KindCount));
      c.first = view_arg[10:0];
      c.last = view_arg[10:0];
    end else if (view_mode == MODE_GROUP) begin
      sel_ok = (view_arg >= 16'd1) && (view_arg <= 16'd9);
      c.first = group_bound(view_arg[3:0] - 4'd1) + 11'd1;
      c.last = group_bound(view_arg[3:0]);
    end else if (view_mode > MODE_FLAGGED) begin
      sel_ok = 1'b0;
    end
    case (req_type)
      REQ_CLEAR:  c.ok = 1'b1;
      REQ_ADD:    c.ok = add_ok;
      REQ_SELECT: c.ok = sel_ok;
      default:    c.ok = 1'b0;
    endcase
  end

  // Track the record count here so add checks need nothing from the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      tot <= '0;
    end else if (acc) begin
      if (req_type == REQ_CLEAR) tot <= '0;
      else if (req_type == REQ_ADD && add_ok) tot <= tot + 1'b1;
    end
  end

  assign q_push = acc;
  assign q_cmd  = c;
endmodule

>>> rtl/core/fsei_queue.sv
// Two-entry queue of commands between front and back.
module fsei_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsei_pkg::cmd_t din,
  input  logic           pop,
  output logic           full,
  output logic           avail,
  output fsei_pkg::cmd_t dout
);
  import fsei_pkg::*;

  cmd_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign avail = cnt != 2'd0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/core/fsei_back.sv
// Back: record store, order list, filter and insertion sort sequencer.
module fsei_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  fsei_pkg::cmd_t cmd,
  output logic           pop,
  output logic           done,
  output logic           ok,
  output logic [10:0]    match_count,
  output logic [31:0]    out_id,
  output logic [9:0]     out_slot,
  output logic [10:0]    out_kind,
  output logic           out_flag
);
  import fsei_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_FILT  = 8'b00000100,
    S_OUTER = 8'b00001000,
    S_CUR   = 8'b00010000,
    S_CMP   = 8'b00100000,
    S_SHIFT = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t state, state_next;
  rec_t store [Capacity];
  logic [IdxW-1:0] order [Capacity];
  logic [CntW-1:0] rtot, otot, n, i, j;
  logic [CntW-1:0] fi;
  logic [IdxW-1:0] cur_idx, prev_idx;
  rec_t cur_rec, srd;
  logic [IdxW-1:0] ord_rd;
  cmd_t c;
  logic rd_hit, fvalid, rd_ok;

  assign match_count = otot;

  // A read finds a record only below the current row count.
  assign rd_ok = (cmd.row < 16'(Capacity)) && (cmd.row[CntW-1:0] < otot);

  // Store port: one write, one registered read.
  logic [IdxW-1:0] s_ra;
  logic            s_we;
  logic [IdxW-1:0] s_wa;
  rec_t            s_wd;
  always_ff @(posedge clk) begin
    if (s_we) store[s_wa] <= s_wd;
    srd <= store[s_ra];
  end

  // Order list port.
  logic [IdxW-1:0] o_ra, o_wa, o_wd;
  logic            o_we;
  always_ff @(posedge clk) begin
    if (o_we) order[o_wa] <= o_wd;
    ord_rd <= order[o_ra];
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    s_we = 1'b0; s_wa = rtot[IdxW-1:0]; s_wd = cmd.rec;
    s_ra = fi[IdxW-1:0];
    o_we = 1'b0; o_wa = n[IdxW-1:0]; o_wd = fi[IdxW-1:0];
    o_ra = cmd.row[IdxW-1:0];
    unique case (state)
      S_IDLE: if (avail) begin
        pop = 1'b1;
        if (cmd.req == REQ_ADD && cmd.ok) s_we = 1'b1;
        if (cmd.req == REQ_SELECT && cmd.ok) begin
          s_ra = '0;
          state_next = S_FILT;
        end else if (cmd.req == REQ_READ && rd_ok) state_next = S_READ;
      end
      S_READ: begin
        s_ra = ord_rd;
        state_next = S_FIN;
      end
      S_FILT: begin
        s_ra = fi[IdxW-1:0] + 1'b1;
        if (fvalid && srd.kind >= c.first && srd.kind <= c.last &&
            (c.mode != MODE_FLAGGED || srd.flag)) begin
          o_we = 1'b1; o_wa = n[IdxW-1:0]; o_wd = fi[IdxW-1:0];
        end
        if (!fvalid || fi + 1'b1 >= rtot) state_next = S_OUTER;
      end
      S_OUTER: begin
        o_ra = i[IdxW-1:0];
        state_next = (i < n) ? S_CUR : S_FIN;
      end
      S_CUR: begin
        s_ra = ord_rd;
        o_ra = j[IdxW-1:0] - 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        s_ra = ord_rd;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        o_ra = j[IdxW-1:0] - IdxW'(2);
        if (j != '0 && goes_before(cur_rec, srd, c.mode)) begin
          o_we = 1'b1; o_wa = j[IdxW-1:0]; o_wd = prev_idx;
          state_next = (j == CntW'(1)) ? S_SHIFT : S_CMP;
        end else begin
          o_we = 1'b1; o_wa = j[IdxW-1:0]; o_wd = cur_idx;
          state_next = S_OUTER;
        end
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rtot <= '0;
      otot <= '0;
      done <= 1'b0;
      rd_hit <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (avail) begin
          c <= cmd;
          fi <= '0;
          n <= '0;
          rd_hit <= 1'b0;
          fvalid <= rtot != '0;
          ok <= cmd.ok; out_id <= '0; out_slot <= '0; out_kind <= '0; out_flag <= 1'b0;
          if (cmd.req == REQ_CLEAR) begin
            rtot <= '0; otot <= '0; done <= 1'b1;
          end else if (cmd.req == REQ_ADD) begin
            if (cmd.ok) rtot <= rtot + 1'b1;
            done <= 1'b1;
          end else if (cmd.req == REQ_SELECT) begin
            if (!cmd.ok) done <= 1'b1;
          end else begin
            rd_hit <= rd_ok;
            if (!rd_ok) begin
              ok <= 1'b0;
              done <= 1'b1;
            end
          end
        end
        S_READ: ;
        S_FILT: begin
          if (fvalid && srd.kind >= c.first && srd.kind <= c.last &&
              (c.mode != MODE_FLAGGED || srd.flag)) n <= n + 1'b1;
          fi <= fi + 1'b1;
          i <= CntW'(1);
        end
        S_OUTER: begin
          j <= i;
          i <= i + 1'b1;
        end
        S_CUR: begin
          cur_idx <= ord_rd;
        end
        S_CMP: begin
          cur_rec <= (j == i - 1'b1) ? srd : cur_rec;
          prev_idx <= ord_rd;
        end
        S_SHIFT: begin
          if (j != '0 && goes_before(cur_rec, srd, c.mode)) j <= j - 1'b1;
        end
        S_FIN: begin
          done <= 1'b1;
          if (rd_hit) begin
            ok <= 1'b1;
            out_id <= srd.id; out_slot <= srd.slot;
            out_kind <= srd.kind; out_flag <= srd.flag;
          end else begin
            ok <= 1'b1;
            otot <= n;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/filtered_sorted_entry_index_top.sv
// Top level: front, command queue and back of the filtered sorted entry index.
// Requests enter when start is high and busy low; busy is high in reset and while two
// items wait in the queue. Each item gives one result strobed by done for one cycle,
// which the receiver must take, as it cannot stall. A clear, an add, a rejected select
// or a read of a missing row is written into the queue, and the back registers done as
// it pops the command; a valid read goes through S_READ and S_FIN first. A select scans
// the r stored records one per cycle, then insertion-sorts the m matches, each compare
// passing through S_CMP and S_SHIFT, paced by the single read port of each table.
module filtered_sorted_entry_index_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] rec_id,
  input  logic [15:0] rec_slot,
  input  logic [15:0] rec_kind,
  input  logic        rec_flag,
  input  logic [2:0]  view_mode,
  input  logic [15:0] view_arg,
  input  logic [15:0] row_index,
  output logic        done,
  output logic        ok,
  output logic [10:0] match_count,
  output logic [31:0] out_id,
  output logic [9:0]  out_slot,
  output logic [10:0] out_kind,
  output logic        out_flag
);
  import fsei_pkg::*;

  cmd_t q_in, q_out;
  logic q_push, q_full, q_avail, q_pop;

  fsei_front u_front (
    .clk, .rst, .start, .q_full, .req_type, .rec_id, .rec_slot, .rec_kind,
    .rec_flag, .view_mode, .view_arg, .row_index, .busy,
    .q_push, .q_cmd(q_in)
  );

  fsei_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .pop(q_pop),
    .full(q_full), .avail(q_avail), .dout(q_out)
  );

  fsei_back u_back (
    .clk, .rst, .avail(q_avail), .cmd(q_out), .pop(q_pop), .done, .ok,
    .match_count, .out_id, .out_slot, .out_kind, .out_flag
  );
endmodule
